[rtl/cfsi_pkg.sv]
// Shared types, register codes and constants of the carved file size inference block.
`timescale 1ns / 1ps
package cfsi_pkg;

  localparam int unsigned SizeW                 = 40;
  localparam int unsigned LeadBytes             = 8;
  localparam int unsigned DefaultSizeBits       = 40;
  localparam int unsigned DefaultMaxFooterBytes = 8;
  localparam int unsigned ApbDataW              = 64;
  localparam int unsigned ApbAddrW              = 6;

  localparam logic [SizeW-1:0] Mib32          = SizeW'(32 * 1024 * 1024);
  localparam logic [SizeW-1:0] Mib8           = SizeW'(8 * 1024 * 1024);
  localparam logic [SizeW-1:0] Mib4           = SizeW'(4 * 1024 * 1024);
  localparam logic [SizeW-1:0] DefaultMaxSize = SizeW'(1073741824);
  localparam logic [31:0]      BmpMin         = 32'd14;
  localparam logic [31:0]      RiffMin        = 32'd12;
  localparam logic [31:0]      BoxMin         = 32'd8;
  localparam logic [31:0]      RiffBias       = 32'd8;

  typedef enum logic [2:0] {
    RuleBitmap = 3'd0,
    RuleRiff   = 3'd1,
    RuleFooter = 3'd2,
    RuleMp4    = 3'd3,
    RuleNone   = 3'd4
  } size_rule_e;

  typedef enum logic [2:0] {
    SrcHeader      = 3'd0,
    SrcFooter      = 3'd1,
    SrcMp4         = 3'd2,
    SrcFootDefault = 3'd3,
    SrcPlain       = 3'd4
  } size_source_e;

  typedef enum logic [2:0] {
    RegSizeRule     = 3'd0,
    RegMaxSize      = 3'd1,
    RegVolumeRemain = 3'd2,
    RegHeaderLength = 3'd3,
    RegFooterPat    = 3'd4,
    RegFooterLength = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [SizeW-1:0] inferred_size;
    logic [2:0]       size_source;
  } out_t;

  typedef struct packed {
    logic [2:0]       size_rule;
    logic [SizeW-1:0] max_size;
    logic [SizeW-1:0] volume_remain;
    logic [4:0]       header_length;
    logic [63:0]      footer_pattern;
    logic [3:0]       footer_length;
    logic [SizeW-1:0] cap;
  } cfg_t;

  typedef struct packed {
    logic [8*LeadBytes-1:0] lead;
    logic                   at_least6;
    logic                   at_least8;
    logic                   foot_seen;
    logic [SizeW-1:0]       foot_end;
  } scan_t;

endpackage

[rtl/carved_file_size_inference_top.sv]
// Top level of the carved file size inference block.
`timescale 1ns / 1ps
// Carved file size inference. Bytes of a carved file candidate stream in from
// offset zero, one transaction per byte, the final byte of a run flagged by
// last_byte; that byte yields exactly one transaction on the output with the
// estimated size and where the estimate came from, and every other byte yields
// none. The block takes one byte per clock cycle: an input register holds the
// accepted byte, logic after it updates the run state (position counter,
// leading bytes, recent-byte window and footer match) and evaluates the size
// rule, and a result register holds the answer, loaded when the last byte
// leaves the input register. in_stall_o rises only when a last byte sits
// in the input register while the result register is still full and stalled;
// ordinary bytes keep flowing under an output stall. Configuration is a 64-bit
// APB port, register i at byte address 8*i, always ready; write it only while
// no run is in flight and no result is waiting.
module carved_file_size_inference_top import cfsi_pkg::*; #(
  parameter int unsigned SizeBits       = DefaultSizeBits,
  parameter int unsigned MaxFooterBytes = DefaultMaxFooterBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t  cfg;
  scan_t scan;
  out_t  res;

  logic  in_vld_q, in_vld_d;
  in_t   in_q;
  logic  out_vld_q, out_vld_d;
  out_t  out_q;

  logic  in_accept;
  logic  out_free;
  logic  proc_ok;
  logic  proc;
  logic  out_load;

  assign pready = 1'b1;

  cfsi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // The output register frees up this cycle when empty or being taken.
  assign out_free = !out_vld_q || !out_stall_i;
  // A byte without a result always advances; a last byte needs the output slot.
  assign proc_ok  = !in_q.last_byte || out_free;
  assign proc     = in_vld_q && proc_ok;
  assign out_load = proc && in_q.last_byte;

  assign in_stall_o = in_vld_q && !proc_ok;
  assign in_accept  = in_valid_i && !in_stall_o;

  cfsi_scan #(
    .SizeBits       (SizeBits),
    .MaxFooterBytes (MaxFooterBytes)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (proc),
    .byte_i   (in_q.data_byte),
    .last_i   (in_q.last_byte),
    .cfg_i    (cfg),
    .status_o (scan)
  );

  cfsi_rules u_rules (
    .cfg_i  (cfg),
    .scan_i (scan),
    .res_o  (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end

    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Hold control state under reset; payload registers load on demand only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && in_q.last_byte && out_vld_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.inferred_size <= cfg.cap))
    else $error("size estimate above cap");
`endif

endmodule

[rtl/cfsi_regs.sv]
// APB register file and size cap of the carved file size inference block.
`timescale 1ns / 1ps
module cfsi_regs import cfsi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output cfg_t                cfg_o
);

  logic [2:0]       rule_q;
  logic [SizeW-1:0] max_q;
  logic [SizeW-1:0] vol_q;
  logic [4:0]       hlen_q;
  logic [63:0]      fpat_q;
  logic [3:0]       flen_q;
  logic             wr_en;
  logic [2:0]       idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[ApbAddrW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= RuleNone;
      max_q  <= DefaultMaxSize;
      vol_q  <= '0;
      hlen_q <= '0;
      fpat_q <= '0;
      flen_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegSizeRule:     rule_q <= pwdata[2:0];
        RegMaxSize:      max_q  <= pwdata[SizeW-1:0];
        RegVolumeRemain: vol_q  <= pwdata[SizeW-1:0];
        RegHeaderLength: hlen_q <= pwdata[4:0];
        RegFooterPat:    fpat_q <= pwdata;
        RegFooterLength: flen_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegSizeRule:     prdata = ApbDataW'(rule_q);
      RegMaxSize:      prdata = ApbDataW'(max_q);
      RegVolumeRemain: prdata = ApbDataW'(vol_q);
      RegHeaderLength: prdata = ApbDataW'(hlen_q);
      RegFooterPat:    prdata = fpat_q;
      RegFooterLength: prdata = ApbDataW'(flen_q);
      default:         prdata = '0;
    endcase
  end

  // Lower the cap to the volume space when that limit is set and tighter.
  always_comb begin
    cfg_o.size_rule      = rule_q;
    cfg_o.max_size       = max_q;
    cfg_o.volume_remain  = vol_q;
    cfg_o.header_length  = hlen_q;
    cfg_o.footer_pattern = fpat_q;
    cfg_o.footer_length  = flen_q;
    cfg_o.cap            = ((vol_q != '0) && (vol_q < max_q)) ? vol_q : max_q;
  end

endmodule

[rtl/cfsi_scan.sv]
// Per-run byte tracker: position counter, leading bytes, recent window and footer match.
`timescale 1ns / 1ps
module cfsi_scan import cfsi_pkg::*; #(
  parameter int unsigned SizeBits       = DefaultSizeBits,
  parameter int unsigned MaxFooterBytes = DefaultMaxFooterBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output scan_t      status_o
);

  localparam int unsigned CntW = SizeBits + 1;
  localparam int unsigned CmpW = (CntW > SizeW) ? CntW : SizeW;
  localparam int unsigned FlW  = $clog2(MaxFooterBytes + 1);

  logic [SizeBits-1:0] pos_q, pos_d;
  logic                seen_q, seen_d;
  logic [SizeBits-1:0] fend_q, fend_d;
  logic [7:0]          lead_q [LeadBytes];
  logic [7:0]          lead_d [LeadBytes];
  logic [7:0]          win_q  [MaxFooterBytes];
  logic [7:0]          win_d  [MaxFooterBytes];
  logic [MaxFooterBytes:0] match_len;
  logic [CntW-1:0]     count;
  logic [3:0]          flen_w;
  logic [FlW-1:0]      flen;
  logic [5:0]          thresh;
  logic                hit;
  logic [CmpW-1:0]     fend_wide;

  always_comb begin
    count = {1'b0, pos_q} + CntW'(1);
    pos_d = (&pos_q) ? pos_q : pos_q + SizeBits'(1);

    for (int k = 0; k < LeadBytes; k++) begin
      lead_d[k] = (pos_q == SizeBits'(k)) ? byte_i : lead_q[k];
    end

    // Newest byte at age zero.
    win_d[0] = byte_i;
    for (int k = 1; k < MaxFooterBytes; k++) begin
      win_d[k] = win_q[k-1];
    end

    // Footer byte j lines up with the byte of age (length - 1 - j).
    match_len[0] = 1'b0;
    for (int l = 1; l <= MaxFooterBytes; l++) begin
      match_len[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (win_d[l-1-j] != cfg_i.footer_pattern[8*j +: 8]) begin
          match_len[l] = 1'b0;
        end
      end
    end

    flen_w = (cfg_i.footer_length > 4'(MaxFooterBytes)) ? 4'(MaxFooterBytes)
                                                        : cfg_i.footer_length;
    flen   = flen_w[FlW-1:0];
    thresh = 6'(flen_w) + 6'(cfg_i.header_length);

    hit = !seen_q && (flen_w != '0) &&
          (CmpW'(count) >= CmpW'(thresh)) &&
          (CmpW'(count) <= CmpW'(cfg_i.cap)) &&
          match_len[flen];

    seen_d    = seen_q | hit;
    fend_d    = hit ? count[SizeBits-1:0] : fend_q;
    fend_wide = CmpW'(fend_d);
  end

  always_comb begin
    for (int k = 0; k < LeadBytes; k++) begin
      status_o.lead[8*k +: 8] = lead_d[k];
    end
    status_o.at_least6 = (count >= CntW'(6));
    status_o.at_least8 = (count >= CntW'(8));
    status_o.foot_seen = seen_d;
    status_o.foot_end  = fend_wide[SizeW-1:0];
  end

  // Run state clears on the last byte; window and leading bytes are only read
  // at ages and offsets this run has already filled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= 1'b0;
      fend_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q  <= '0;
        seen_q <= 1'b0;
        fend_q <= '0;
      end else begin
        pos_q  <= pos_d;
        seen_q <= seen_d;
        fend_q <= fend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      lead_q <= lead_d;
      win_q  <= win_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (pos_q == '0 && !seen_q))
    else $error("run state not cleared after last byte");

  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |=> (seen_q || $past(step_i && last_i)))
    else $error("footer match lost inside a run");
`endif

endmodule

[rtl/cfsi_rules.sv]
// Size rule evaluation on the last byte of a run.
`timescale 1ns / 1ps
module cfsi_rules import cfsi_pkg::*; (
  input  cfg_t  cfg_i,
  input  scan_t scan_i,
  output out_t  res_o
);

  logic [31:0]      bmp_len;
  logic [31:0]      riff_len;
  logic [31:0]      box_len;
  logic [SizeW-1:0] cap;
  logic             done;

  assign cap      = cfg_i.cap;
  assign bmp_len  = scan_i.lead[47:16];
  assign riff_len = scan_i.lead[63:32] + RiffBias;
  assign box_len  = {scan_i.lead[7:0], scan_i.lead[15:8],
                     scan_i.lead[23:16], scan_i.lead[31:24]};

  always_comb begin
    done                = 1'b0;
    res_o.inferred_size = '0;
    res_o.size_source   = SrcPlain;
    priority if (cfg_i.size_rule == RuleBitmap && scan_i.at_least6) begin
      if (bmp_len >= BmpMin && SizeW'(bmp_len) <= cap) begin
        res_o.inferred_size = SizeW'(bmp_len);
        res_o.size_source   = SrcHeader;
        done                = 1'b1;
      end
    end else if (cfg_i.size_rule == RuleRiff && scan_i.at_least8) begin
      if (riff_len >= RiffMin && SizeW'(riff_len) <= cap) begin
        res_o.inferred_size = SizeW'(riff_len);
        res_o.size_source   = SrcHeader;
        done                = 1'b1;
      end
    end else if (cfg_i.size_rule == RuleFooter) begin
      if (scan_i.foot_seen) begin
        res_o.inferred_size = scan_i.foot_end;
        res_o.size_source   = SrcFooter;
        done                = 1'b1;
      end
    end else if (cfg_i.size_rule == RuleMp4 && scan_i.at_least8) begin
      if (box_len >= BoxMin && SizeW'(box_len) <= cap) begin
        res_o.inferred_size = (cap < Mib32) ? cap : Mib32;
        res_o.size_source   = SrcMp4;
        done                = 1'b1;
      end
    end else begin
    end

    if (!done) begin
      if (cfg_i.footer_length != '0) begin
        res_o.inferred_size = (cap < Mib8) ? cap : Mib8;
        res_o.size_source   = SrcFootDefault;
      end else begin
        res_o.inferred_size = (cap < Mib4) ? cap : Mib4;
        res_o.size_source   = SrcPlain;
      end
    end
  end

endmodule
